// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BVG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BVG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/bvg_pkg.sv =====
package bvg_pkg;

   localparam int SAMPLE_COUNT_DEF = 8;

   localparam int SAMPLE_W   = 12;
   localparam int RATIO_W    = 4;
   localparam int SUM_W      = 21;
   localparam int MV_W       = 15;
   localparam int PCT_W      = 7;
   localparam int DIVIDEND_W = 12;
   localparam int DIVISOR_W  = 12;
   localparam int CURVE_W    = 13;
   localparam int SEG_W      = 4;

   localparam int RAW_FULL_MV   = 3300;
   localparam int RAW_FULL_CODE = 4095;

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   localparam int CURVE_POINTS = 11;

   localparam logic [CURVE_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4110, 13'd4030, 13'd3980, 13'd3920, 13'd3870,
      13'd3830, 13'd3790, 13'd3740, 13'd3680, 13'd3400
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
      7'd40, 7'd30, 7'd20, 7'd10, 7'd0
   };

   localparam logic CSR_CALI_OK = 1'b0;
   localparam logic CSR_DIVIDER = 1'b1;

   localparam logic [RATIO_W-1:0] DIVIDER_RESET = 4'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                read_failed;
   } bvg_req_type;

   typedef struct packed {
      logic [MV_W-1:0]  battery_mv;
      logic [PCT_W-1:0] percent;
      logic             status;
   } bvg_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCALE,
      ST_ACCUM,
      ST_AVG,
      ST_SEG,
      ST_INTERP,
      ST_EMIT
   } bvg_state_type;

   typedef struct packed {
      logic load_in;
      logic pin_from_sample;
      logic pin_from_scale;
      logic accum;
      logic div_start;
      logic mv_from_avg;
      logic seg_eval;
      logic pct_from_div;
      logic emit;
   } bvg_cmd_type;

   typedef struct packed {
      logic failed;
      logic cali_ok;
      logic div_done;
      logic pct_direct;
      logic rsp_free;
   } bvg_status_type;

endpackage

// ===== src/bvg_div.sv =====
module bvg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [bvg_pkg::DIVIDEND_W-1:0]       dividend,
   input  logic [bvg_pkg::DIVISOR_W-1:0]        divisor,
   output logic [bvg_pkg::DIVIDEND_W-1:0]       quotient,
   output logic                                 done
);

   localparam int DVD_W = bvg_pkg::DIVIDEND_W;
   localparam int DVS_W = bvg_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   trial;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      trial     = rem_shift - {1'b0, dvs_ff};
      fits      = rem_shift >= {1'b0, dvs_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(DVD_W);
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         rem_in  = fits ? trial[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== src/bvg_datapath.sv =====
module bvg_datapath #(
   parameter int SAMPLE_COUNT = bvg_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bvg_pkg::bvg_cmd_type            cmd,
   output bvg_pkg::bvg_status_type         status,
   input  logic                            cali_ok,
   input  logic [bvg_pkg::RATIO_W-1:0]     divider_ratio,
   input  bvg_pkg::bvg_req_type            req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bvg_pkg::bvg_rsp_type            rsp_payload
);

   localparam int SAMPLE_W = bvg_pkg::SAMPLE_W;
   localparam int SUM_W    = bvg_pkg::SUM_W;
   localparam int MV_W     = bvg_pkg::MV_W;
   localparam int PCT_W    = bvg_pkg::PCT_W;
   localparam int DVD_W    = bvg_pkg::DIVIDEND_W;
   localparam int DVS_W    = bvg_pkg::DIVISOR_W;
   localparam int CURVE_W  = bvg_pkg::CURVE_W;
   localparam int SEG_W    = bvg_pkg::SEG_W;

   localparam int SCALE_W   = 2 * SAMPLE_W;
   localparam int AVG_L     = $clog2(SAMPLE_COUNT);
   localparam int AVG_SHIFT = SUM_W + AVG_L;
   localparam int PROD_W    = 2 * SUM_W + 1;
   localparam longint AVG_RECIP =
      ((longint'(1) << AVG_SHIFT) + longint'(SAMPLE_COUNT) - 1) / longint'(SAMPLE_COUNT);

   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 failed_ff, failed_in;
   logic [SAMPLE_W-1:0]  pin_ff, pin_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [MV_W-1:0]      mv_ff, mv_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bvg_pkg::bvg_rsp_type rsp_ff, rsp_in;

   logic [DVD_W-1:0]     div_dividend;
   logic [DVS_W-1:0]     div_divisor;
   logic [DVD_W-1:0]     div_quotient;
   logic                 div_done;

   logic [SCALE_W-1:0]   scale_prod;
   logic [SAMPLE_W-1:0]  scale_q0;
   logic [SAMPLE_W:0]    scale_rem;
   logic [SAMPLE_W-1:0]  scale_mv;
   logic [PROD_W-1:0]    avg_prod;
   logic [SUM_W-1:0]     avg_q;

   logic [SUM_W:0]       sum_wide;
   logic [SEG_W-1:0]     seg_k;
   logic                 seg_found;
   logic                 mv_top;
   logic [CURVE_W-1:0]   seg_lo;
   logic [CURVE_W-1:0]   seg_dv;
   logic [CURVE_W-1:0]   seg_diff;
   logic [PCT_W-1:0]     seg_dp;
   logic [PCT_W-1:0]     seg_base;
   logic                 rsp_free;

   always_comb begin
      seg_k     = '0;
      seg_found = 1'b0;
      for (int k = bvg_pkg::CURVE_POINTS - 2; k >= 0; k--) begin
         if (mv_ff >= MV_W'(bvg_pkg::CURVE_MV[k+1])) begin
            seg_k     = SEG_W'(k);
            seg_found = 1'b1;
         end
      end
      mv_top   = mv_ff >= MV_W'(bvg_pkg::CURVE_MV[0]);
      seg_lo   = bvg_pkg::CURVE_MV[seg_k + SEG_W'(1)];
      seg_dv   = bvg_pkg::CURVE_MV[seg_k] - seg_lo;
      seg_diff = CURVE_W'(mv_ff - MV_W'(seg_lo));
      seg_base = bvg_pkg::CURVE_PCT[seg_k + SEG_W'(1)];
      seg_dp   = bvg_pkg::CURVE_PCT[seg_k] - seg_base;
   end

   // Division by 4095 is a shift by 12 plus one correction step, since 4095 is 4096 - 1.
   // The average uses a reciprocal multiply that is exact for every sum of SUM_W bits.
   always_comb begin
      scale_prod = SCALE_W'(sample_ff) * SCALE_W'(bvg_pkg::RAW_FULL_MV);
      scale_q0   = scale_prod[SCALE_W-1:SAMPLE_W];
      scale_rem  = {1'b0, scale_prod[SAMPLE_W-1:0]} + {1'b0, scale_q0};
      scale_mv   = scale_q0 +
                   SAMPLE_W'(scale_rem >= (SAMPLE_W + 1)'(bvg_pkg::RAW_FULL_CODE));
      avg_prod   = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);
      avg_q      = SUM_W'(avg_prod >> AVG_SHIFT);
   end

   assign div_dividend = DVD_W'(seg_diff) * DVD_W'(seg_dp);
   assign div_divisor  = DVS_W'(seg_dv);

   bvg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sample_in    = sample_ff;
      failed_in    = failed_ff;
      pin_in       = pin_ff;
      sum_in       = sum_ff;
      mv_in        = mv_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      sum_wide     = {1'b0, sum_ff} + (SUM_W + 1)'(pin_ff) * (SUM_W + 1)'(divider_ratio);

      if (cmd.load_in) begin
         sample_in = req_payload.sample;
         failed_in = req_payload.read_failed;
      end
      if (cmd.pin_from_sample) begin
         pin_in = sample_ff;
      end
      if (cmd.pin_from_scale) begin
         pin_in = scale_mv;
      end
      if (cmd.accum) begin
         sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      end
      if (cmd.mv_from_avg) begin
         mv_in = (avg_q[SUM_W-1:MV_W] != '0) ? '1 : avg_q[MV_W-1:0];
      end
      if (cmd.seg_eval) begin
         if (mv_top) begin
            pct_in = bvg_pkg::PCT_FULL;
         end else if (!seg_found) begin
            pct_in = bvg_pkg::PCT_EMPTY;
         end else begin
            pct_in = seg_base;
         end
      end
      if (cmd.pct_from_div) begin
         pct_in = pct_ff + div_quotient[PCT_W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         sum_in       = '0;
         if (failed_ff) begin
            rsp_in.battery_mv = '0;
            rsp_in.percent    = '0;
            rsp_in.status     = 1'b1;
         end else begin
            rsp_in.battery_mv = mv_ff;
            rsp_in.percent    = pct_ff;
            rsp_in.status     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      failed_ff <= failed_in;
      pin_ff    <= pin_in;
      mv_ff     <= mv_in;
      pct_ff    <= pct_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.failed     = failed_ff;
   assign status.cali_ok    = cali_ok;
   assign status.div_done   = div_done;
   assign status.pct_direct = mv_top || !seg_found;
   assign status.rsp_free   = rsp_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/bvg_ctrl.sv =====
module bvg_ctrl #(
   parameter int SAMPLE_COUNT = bvg_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output bvg_pkg::bvg_cmd_type    cmd,
   input  bvg_pkg::bvg_status_type status
);

   localparam int IDX_W = $clog2(SAMPLE_COUNT + 1);

   bvg_pkg::bvg_state_type state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   batch_full;

   assign batch_full = idx_ff == IDX_W'(SAMPLE_COUNT - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bvg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bvg_pkg::ST_DECIDE;
            end
         end
         bvg_pkg::ST_DECIDE: begin
            if (status.failed) begin
               state_in = bvg_pkg::ST_EMIT;
            end else if (status.cali_ok) begin
               state_in = bvg_pkg::ST_ACCUM;
            end else begin
               state_in = bvg_pkg::ST_SCALE;
            end
         end
         bvg_pkg::ST_SCALE: begin
            state_in = bvg_pkg::ST_ACCUM;
         end
         bvg_pkg::ST_ACCUM: begin
            state_in = batch_full ? bvg_pkg::ST_AVG : bvg_pkg::ST_IDLE;
         end
         bvg_pkg::ST_AVG: begin
            state_in = bvg_pkg::ST_SEG;
         end
         bvg_pkg::ST_SEG: begin
            state_in = status.pct_direct ? bvg_pkg::ST_EMIT : bvg_pkg::ST_INTERP;
         end
         bvg_pkg::ST_INTERP: begin
            if (status.div_done) begin
               state_in = bvg_pkg::ST_EMIT;
            end
         end
         bvg_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = bvg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bvg_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      idx_in    = idx_ff;
      unique case (state_ff)
         bvg_pkg::ST_IDLE: begin
            req_stall   = reset;
            cmd.load_in = req_valid;
         end
         bvg_pkg::ST_DECIDE: begin
            if (!status.failed && status.cali_ok) begin
               cmd.pin_from_sample = 1'b1;
            end
         end
         bvg_pkg::ST_SCALE: begin
            cmd.pin_from_scale = 1'b1;
         end
         bvg_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
         end
         bvg_pkg::ST_AVG: begin
            cmd.mv_from_avg = 1'b1;
         end
         bvg_pkg::ST_SEG: begin
            cmd.seg_eval  = 1'b1;
            cmd.div_start = !status.pct_direct;
         end
         bvg_pkg::ST_INTERP: begin
            cmd.pct_from_div = status.div_done;
         end
         bvg_pkg::ST_EMIT: begin
            cmd.emit = status.rsp_free;
            if (status.rsp_free) begin
               idx_in = '0;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bvg_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== src/battery_voltage_gauge_core.sv =====
// Averages SAMPLE_COUNT battery ADC samples (raw codes scaled by 3300/4095, or
// calibrated millivolts when cali_ok is set, times divider_ratio) and returns
// one transaction per batch with the average battery millivolts and a LiPo
// state-of-charge percent; a failed read returns an error transaction and
// restarts the batch. One sample at a time is in work: a calibrated one passes
// the decide and accumulate states before the next acceptance, a raw code also
// the scale state, a failed read the output write. The last sample of a batch
// adds the average, curve lookup and output write, and a wait while the 12-step
// restoring divider interpolates the percent between curve points. A finished
// result waits in an output register, so the next sample is taken while it is
// still stalled; only a further result waits for that register to drain.
`include "assert_macros.svh"

module battery_voltage_gauge_core #(
   parameter int SAMPLE_COUNT = bvg_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bvg_pkg::bvg_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bvg_pkg::bvg_rsp_type rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int RATIO_W = bvg_pkg::RATIO_W;

   logic                     cali_ok_ff, cali_ok_in;
   logic [RATIO_W-1:0]       ratio_ff, ratio_in;
   logic                     csr_write;
   bvg_pkg::bvg_cmd_type     cmd;
   bvg_pkg::bvg_status_type  status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cali_ok_in = cali_ok_ff;
      ratio_in   = ratio_ff;
      if (csr_write) begin
         unique case (paddr[2])
            bvg_pkg::CSR_CALI_OK: cali_ok_in = pwdata[0];
            bvg_pkg::CSR_DIVIDER: ratio_in   = pwdata[RATIO_W-1:0];
            default:              cali_ok_in = cali_ok_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         bvg_pkg::CSR_CALI_OK: prdata = 32'(cali_ok_ff);
         bvg_pkg::CSR_DIVIDER: prdata = 32'(ratio_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cali_ok_ff <= 1'b1;
         ratio_ff   <= bvg_pkg::DIVIDER_RESET;
      end else begin
         cali_ok_ff <= cali_ok_in;
         ratio_ff   <= ratio_in;
      end
   end

   bvg_ctrl #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bvg_datapath #(
      .SAMPLE_COUNT (SAMPLE_COUNT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cali_ok       (cali_ok_ff),
      .divider_ratio (ratio_ff),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

   `BVG_ASSERT_IMPL(a_pct_range, clock, reset, rsp_valid, rsp_payload.percent <= 7'd100)
   `BVG_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_payload.status, rsp_payload.battery_mv == '0 && rsp_payload.percent == '0)
   `BVG_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall)

endmodule

// ===== verif/battery_voltage_gauge_core_tb.sv =====
`timescale 1ns / 100ps

module battery_voltage_gauge_core_tb;

   localparam int SAMPLES_PER_READING = bvg_pkg::SAMPLE_COUNT_DEF;
   localparam int unsigned SUM_LIMIT = 32'h1F_FFFF;
   localparam int unsigned MV_LIMIT = 32'h7FFF;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int PHASES = 7;

   localparam logic [2:0] ADDR_CALI_OK = {bvg_pkg::CSR_CALI_OK, 2'b00};
   localparam logic [2:0] ADDR_DIVIDER = {bvg_pkg::CSR_DIVIDER, 2'b00};

   localparam int unsigned SOC_MV [11] = '{
      4200, 4110, 4030, 3980, 3920, 3870, 3830, 3790, 3740, 3680, 3400
   };
   localparam int unsigned SOC_PCT [11] = '{
      100, 90, 80, 70, 60, 50, 40, 30, 20, 10, 0
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   bvg_pkg::bvg_req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   bvg_pkg::bvg_rsp_type rsp_payload;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [2:0]           paddr;
   logic [31:0]          pwdata;
   logic [31:0]          prdata;
   logic                 pready;

   int errors = 0;
   int cycles = 0;
   int hold_request = 0;

   bvg_pkg::bvg_rsp_type expected_readings[$];

   logic        cfg_cali_ok;
   logic [3:0]  cfg_divider;
   int unsigned gauge_sum;
   int unsigned gauge_count;

   battery_voltage_gauge_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned soc_from_mv(input int unsigned mv);
      int k;
      if (mv >= SOC_MV[0]) return 100;
      for (k = 0; k < 10; k++) begin
         if (mv >= SOC_MV[k+1])
            return SOC_PCT[k+1] + (mv - SOC_MV[k+1]) * (SOC_PCT[k] - SOC_PCT[k+1]) /
                   (SOC_MV[k] - SOC_MV[k+1]);
      end
      return 0;
   endfunction

   // Advances the shadow accumulator by one sample and queues a reading when one is due.
   function automatic void predict_gauge(input bvg_pkg::bvg_req_type item);
      int unsigned pin_mv;
      int unsigned avg;
      bvg_pkg::bvg_rsp_type reading;
      reading = '0;
      if (item.read_failed) begin
         gauge_sum = 0;
         gauge_count = 0;
         reading.status = 1'b1;
         expected_readings.push_back(reading);
         return;
      end
      pin_mv = cfg_cali_ok ? int'(item.sample) : int'(item.sample) * 3300 / 4095;
      gauge_sum += pin_mv * cfg_divider;
      if (gauge_sum > SUM_LIMIT) gauge_sum = SUM_LIMIT;
      gauge_count++;
      if (gauge_count < SAMPLES_PER_READING) return;
      avg = gauge_sum / SAMPLES_PER_READING;
      if (avg > MV_LIMIT) avg = MV_LIMIT;
      gauge_sum = 0;
      gauge_count = 0;
      reading.battery_mv = avg[bvg_pkg::MV_W-1:0];
      reading.percent = 7'(soc_from_mv(avg));
      reading.status = 1'b0;
      expected_readings.push_back(reading);
   endfunction

   always @(posedge clock) begin : check_readings
      bvg_pkg::bvg_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected transaction: battery_mv %0d percent %0d status %0d",
                   rsp_payload.battery_mv, rsp_payload.percent, rsp_payload.status);
            errors++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_payload.battery_mv !== want.battery_mv) begin
               $error("battery_mv expected %0d actual %0d", want.battery_mv,
                      rsp_payload.battery_mv);
               errors++;
            end
            if (rsp_payload.percent !== want.percent) begin
               $error("percent expected %0d actual %0d", want.percent, rsp_payload.percent);
               errors++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_payload.status);
               errors++;
            end
         end
      end
   end

   // The receiver changes its stall rate in stretches, and holds off completely on request.
   initial begin : result_receiver
      int hold_left;
      int stretch_left;
      int stall_pct;
      hold_left = 0;
      stretch_left = 0;
      stall_pct = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(10, 200);
               stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
            end
            stretch_left--;
            rsp_stall = ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_sample(input logic [11:0] sample, input logic failed);
      bvg_pkg::bvg_req_type item;
      item.sample = sample;
      item.read_failed = failed;
      req_payload = item;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_gauge(item);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int gap);
      req_valid = 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] addr, input logic [31:0] want);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = addr;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $error("register %0d expected %0d actual %0d", addr, want, prdata);
         errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [3:0] value);
      logic [31:0] mask;
      mask = (addr == ADDR_CALI_OK) ? 32'h1 : 32'hF;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = addr;
      pwdata = ($urandom() & ~mask) | (32'(value) & mask);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (addr == ADDR_CALI_OK) cfg_cali_ok = value[0];
      else cfg_divider = value;
      csr_read_check(addr, 32'(value) & mask);
   endtask

   task automatic test_reset_values();
      csr_read_check(ADDR_CALI_OK, 32'd1);
      csr_read_check(ADDR_DIVIDER, 32'(bvg_pkg::DIVIDER_RESET));
      send_sample(12'd1400, 1'b1);
   endtask

   task automatic test_average_saturation();
      wait_idle();
      csr_write(ADDR_DIVIDER, 4'd15);
      repeat (SAMPLES_PER_READING) send_sample(12'd4095, 1'b0);
   endtask

   task automatic test_raw_scaling_midbatch();
      wait_idle();
      csr_write(ADDR_CALI_OK, 4'd0);
      csr_write(ADDR_DIVIDER, 4'd0);
      send_sample(12'd4095, 1'b0);
      send_sample(12'd0, 1'b0);
      send_sample(12'd2048, 1'b0);
      wait_idle();
      csr_write(ADDR_DIVIDER, 4'd8);
      send_sample(12'd4095, 1'b0);
      send_sample(12'd4095, 1'b0);
      send_sample(12'd1, 1'b0);
      send_sample(12'd2730, 1'b0);
      send_sample(12'd4094, 1'b0);
   endtask

   task automatic test_abort_midbatch();
      wait_idle();
      csr_write(ADDR_CALI_OK, 4'd1);
      csr_write(ADDR_DIVIDER, 4'd1);
      send_sample(12'd0, 1'b0);
      send_sample(12'd4095, 1'b0);
      send_sample(12'hFFF, 1'b1);
   endtask

   function automatic logic [11:0] pick_batch_level();
      int unsigned target;
      int unsigned div;
      div = (cfg_divider == 0) ? 1 : cfg_divider;
      case ($urandom_range(0, 3))
         0: target = 3300 + $urandom_range(0, 1000);
         1: target = SOC_MV[$urandom_range(0, 10)] + $urandom_range(0, 1);
         2: return 12'($urandom_range(0, 4095));
         default: target = 3350 + $urandom_range(0, 900);
      endcase
      target = target / div;
      if (!cfg_cali_ok) target = (target * 4095 + 3299) / 3300;
      if (target > 4095) target = 4095;
      return target[11:0];
   endfunction

   task automatic send_random_items(input int count, input bit bursty);
      int sent;
      int burst;
      int spread;
      int level;
      int value;
      sent = 0;
      level = 0;
      spread = 0;
      while (sent < count) begin
         burst = bursty ? $urandom_range(1, 24) : count;
         for (int n = 0; n < burst && sent < count; n++) begin
            if (gauge_count == 0) begin
               level = pick_batch_level();
               spread = ($urandom_range(0, 4) == 0) ? 2048 : $urandom_range(0, 3);
            end
            value = level + $urandom_range(0, 2 * spread) - spread;
            if (value < 0) value = 0;
            if (value > 4095) value = 4095;
            send_sample(value[11:0], $urandom_range(0, 99) < 3);
            sent++;
         end
         if (bursty && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
      end
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_request = 600;
      send_random_items(48, 1'b0);
   endtask

   task automatic test_random_phases();
      logic       cali;
      logic [3:0] div;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin cali = 1'b1; div = 4'd1; end
            1: begin cali = 1'b1; div = 4'd8; end
            2: begin cali = 1'b0; div = 4'd1; end
            3: begin cali = 1'b0; div = 4'd8; end
            4: begin cali = 1'b1; div = 4'd15; end
            5: begin cali = 1'b0; div = 4'd0; end
            default: begin cali = $urandom_range(0, 1); div = $urandom_range(1, 8); end
         endcase
         csr_write(ADDR_CALI_OK, {3'b000, cali});
         csr_write(ADDR_DIVIDER, div);
         send_random_items(ITEMS_PER_PHASE, 1'b1);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_cali_ok = 1'b1;
      cfg_divider = bvg_pkg::DIVIDER_RESET;
      gauge_sum = 0;
      gauge_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_average_saturation();
      test_raw_scaling_midbatch();
      test_abort_midbatch();
      test_backpressure();
      test_random_phases();
      wait_idle();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
